// ===== src/sdf_ray_march_light_sampler_core_assert.svh =====
// Assertion macros used by the light sampler core.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef SDF_RAY_MARCH_LIGHT_SAMPLER_CORE_ASSERT_SVH
`define SDF_RAY_MARCH_LIGHT_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication
`define SDFRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDFRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sdfrm_pkg.sv =====
// Package for the light sampler: constants, types, saturation helpers
// and the elaboration-time sine table build. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdfrm_pkg;

  localparam int SAMPLES      = 256;
  localparam int MARCH_STEPS  = 10;
  localparam int TRIG_ENTRIES = 1024;
  localparam int TRIG_BITS    = $clog2(TRIG_ENTRIES);
  localparam int STEP_W       = $clog2(MARCH_STEPS + 1);

  localparam int Q_W     = 20;
  localparam int T_W     = 22;
  localparam int SQ_W    = 42;
  localparam int ROOT_W  = 21;
  localparam int REM_W   = 24;
  localparam int CELLS   = ROOT_W;
  localparam int CNT_W   = 11;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COS,
    ST_SIN,
    ST_ORG,
    ST_CHECK,
    ST_MUL,
    ST_POS,
    ST_SQ,
    ST_SUM,
    ST_WAIT,
    ST_DONE
  } state_e;

  // one square-root digit stage
  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef logic signed [15:0] trig_tab_t [TRIG_ENTRIES];

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W+2:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 23'sd524287) r = 20'sd524287;
    else if (v < -23'sd524288) r = -20'sd524288;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] sat_u(input logic [28:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 29'd524287) r = 20'sd524287;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  // quarter-turn sine, Taylor series to degree 11 in Q30, rounded to Q14
  function automatic logic [15:0] quarter_sine(input logic [14:0] u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (longint'(u) * HALF_PI_Q30) / 16384;
    x2   = (x * x) >> 30;
    term = ((x * x2) >> 30) / 6;
    acc  = longint'(x) - longint'(term);
    term = ((term * x2) >> 30) / 20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 110;
    acc  = acc - longint'(term);
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) acc = 16384;
    return acc[15:0];
  endfunction

  function automatic logic signed [15:0] full_sine(input logic [15:0] a);
    logic [15:0] s;
    if (a[14]) s = quarter_sine(15'd16384 - {1'b0, a[13:0]});
    else s = quarter_sine({1'b0, a[13:0]});
    return a[15] ? -$signed(s) : $signed(s);
  endfunction

  function automatic trig_tab_t build_trig_table();
    trig_tab_t tab;
    logic [15:0] a;
    for (int k = 0; k < TRIG_ENTRIES; k++) begin
      a = 16'(k << (16 - TRIG_BITS));
      tab[k] = full_sine(a);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ===== src/sdfrm_trig_rom.sv =====
// Sine table ROM, one registered read port.
// Depends on sdfrm_pkg for the table contents.
`timescale 1ns / 1ps
`default_nettype none

module sdfrm_trig_rom (
  input  wire logic                           clk_i,
  input  wire logic [sdfrm_pkg::TRIG_BITS-1:0] addr_i,
  output logic signed [15:0]                  data_o
);

  localparam sdfrm_pkg::trig_tab_t Table = sdfrm_pkg::build_trig_table();

  logic signed [15:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= Table[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== src/sdfrm_sqrt_cell.sv =====
// One digit stage of the integer square root chain.
// Depends on sdfrm_pkg (sq_t).
`timescale 1ns / 1ps
`default_nettype none

module sdfrm_sqrt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sdfrm_pkg::sq_t prev_i,
  output sdfrm_pkg::sq_t      next_o
);

  logic [sdfrm_pkg::REM_W-1:0] cur;
  logic [sdfrm_pkg::REM_W-1:0] trial;
  logic                        ge;
  logic                        valid_q;
  logic [sdfrm_pkg::SQ_W-1:0]  rad_q;
  logic [sdfrm_pkg::REM_W-1:0] rem_q;
  logic [sdfrm_pkg::ROOT_W-1:0] root_q;

  // bring down the next two radicand bits, try root*4+1
  assign cur   = {prev_i.rem[sdfrm_pkg::REM_W-3:0], prev_i.rad[sdfrm_pkg::SQ_W-1 -: 2]};
  assign trial = {1'b0, prev_i.root, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {prev_i.rad[sdfrm_pkg::SQ_W-3:0], 2'b00};
    rem_q  <= ge ? cur - trial : cur;
    root_q <= {prev_i.root[sdfrm_pkg::ROOT_W-2:0], ge};
  end

  assign next_o = '{valid: valid_q, rad: rad_q, rem: rem_q, root: root_q};

endmodule

`default_nettype wire

// ===== src/sdfrm_sqrt_chain.sv =====
// Row of square-root digit cells, one result bit per cell per cycle.
// Depends on sdfrm_pkg and sdfrm_sqrt_cell.
`timescale 1ns / 1ps
`default_nettype none

module sdfrm_sqrt_chain (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sdfrm_pkg::sq_t head_i,
  output sdfrm_pkg::sq_t      tail_o
);

  sdfrm_pkg::sq_t link [sdfrm_pkg::CELLS+1];

  assign link[0] = head_i;

  for (genvar g = 0; g < sdfrm_pkg::CELLS; g++) begin : g_cell
    sdfrm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .prev_i (link[g]),
      .next_o (link[g+1])
    );
  end

  assign tail_o = link[sdfrm_pkg::CELLS];

endmodule

`default_nettype wire

// ===== src/sdf_ray_march_light_sampler_core.sv =====
// Sphere-tracing light sampler for one circle: top level with the march sequencer.
// Depends on sdfrm_pkg, sdfrm_trig_rom, sdfrm_sqrt_chain and the assertion header.
//
// Usage: each request on the input channel (in_valid_i / in_stall_o) is one ray of a
// pixel: column, row, angle (65536 = full turn) and a last-sample flag. Rays are taken
// one at a time; in_stall_o stays high while a ray is marching. Each march step
// runs multiply, position, square, then a 21-cell square-root chain; a ray marches
// at most 10 steps. A ray with the last flag set produces one request on the output
// channel (out_valid_o / out_stall_i) with brightness and hit total, then the hit
// count is cleared. The result sits in an output register; the next ray is accepted
// while it waits, but a further last ray holds in its done state until the register
// is free. Reset clears the hit count, empties the output register and loads the
// default circle, scale, limit and threshold. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only while idle, as the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sdf_ray_march_light_sampler_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sdfrm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sdfrm_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [11:0]                       pixel_col_i,
  input  wire logic [11:0]                       pixel_row_i,
  input  wire logic [15:0]                       ray_angle_i,
  input  wire logic                              last_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [7:0]                             brightness_o,
  output logic [10:0]                            hit_total_o
);

`include "sdf_ray_march_light_sampler_core_assert.svh"

  localparam int QW = sdfrm_pkg::Q_W;
  localparam int TW = sdfrm_pkg::T_W;

  // configuration
  logic signed [QW-1:0] cx_q, cy_q;
  logic [18:0]          radius_q;
  logic [16:0]          scale_q;
  logic [18:0]          limit_q;
  logic [15:0]          thr_q;

  sdfrm_pkg::state_e state_q, state_d;

  logic [11:0] col_q, row_q;
  logic [15:0] ang_q;
  logic        last_q;
  logic signed [15:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [QW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [TW-1:0] t_q, t_d;
  logic [sdfrm_pkg::STEP_W-1:0] step_q, step_d;
  logic signed [35:0] px_prod_q, px_prod_d, py_prod_q, py_prod_d;
  logic signed [QW:0] ux_q, ux_d, uy_q, uy_d;
  logic [40:0] sqx_q, sqx_d, sqy_q, sqy_d;
  logic hit_q, hit_d;
  logic [sdfrm_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic out_valid_q, out_valid_d;
  logic [7:0]  bright_q, bright_d;
  logic [10:0] total_q, total_d;

  logic accept;
  logic [sdfrm_pkg::TRIG_BITS-1:0] rom_addr;
  logic signed [15:0] rom_data;
  logic [15:0] cos_ang;
  sdfrm_pkg::sq_t chain_head, chain_tail;

  logic signed [QW+2:0] posx, posy;
  logic signed [QW-1:0] px, py;
  logic signed [2*QW+1:0] ux_sq, uy_sq;
  logic signed [TW-1:0] sd;
  logic [19:0] bright_scaled;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != sdfrm_pkg::ST_IDLE;
  assign cos_ang    = ang_q + 16'd16384;

  sdfrm_trig_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  sdfrm_sqrt_chain u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (chain_head),
    .tail_o (chain_tail)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= 20'sd65536;
      cy_q     <= 20'sd32768;
      radius_q <= 19'd6554;
      scale_q  <= 17'd256;
      limit_q  <= 19'd131072;
      thr_q    <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdfrm_pkg::CFG_CENTER_X:  cx_q     <= cfg_data_i;
        sdfrm_pkg::CFG_CENTER_Y:  cy_q     <= cfg_data_i;
        sdfrm_pkg::CFG_RADIUS:    radius_q <= cfg_data_i[18:0];
        sdfrm_pkg::CFG_SCALE:     scale_q  <= cfg_data_i[16:0];
        sdfrm_pkg::CFG_LIMIT:     limit_q  <= cfg_data_i[18:0];
        sdfrm_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // datapath terms
  assign posx  = {{3{ox_q[QW-1]}}, ox_q} + {px_prod_q[35], px_prod_q[35:14]};
  assign posy  = {{3{oy_q[QW-1]}}, oy_q} + {py_prod_q[35], py_prod_q[35:14]};
  assign px    = sdfrm_pkg::sat_q(posx);
  assign py    = sdfrm_pkg::sat_q(posy);
  assign ux_sq = ux_q * ux_q;
  assign uy_sq = uy_q * uy_q;
  assign sd    = $signed({1'b0, chain_tail.root}) - $signed({3'b000, radius_q});
  assign cnt_next = (hit_q && cnt_q != sdfrm_pkg::COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign bright_scaled = 20'((20'(cnt_next) * 20'd510) / sdfrm_pkg::SAMPLES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdfrm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q  <= pixel_col_i;
      row_q  <= pixel_row_i;
      ang_q  <= ray_angle_i;
      last_q <= last_sample_i;
    end
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    t_q       <= t_d;
    px_prod_q <= px_prod_d;
    py_prod_q <= py_prod_d;
    ux_q      <= ux_d;
    uy_q      <= uy_d;
    sqx_q     <= sqx_d;
    sqy_q     <= sqy_d;
    bright_q  <= bright_d;
    total_q   <= total_d;
  end

  always_comb begin
    state_d     = state_q;
    rom_addr    = ang_q[15 -: sdfrm_pkg::TRIG_BITS];
    dx_d        = dx_q;
    dy_d        = dy_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    t_d         = t_q;
    step_d      = step_q;
    px_prod_d   = px_prod_q;
    py_prod_d   = py_prod_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    hit_d       = hit_q;
    cnt_d       = cnt_q;
    bright_d    = bright_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    chain_head  = '{valid: 1'b0, rad: {sqx_q[40], sqx_q} + {1'b0, sqy_q}, rem: '0, root: '0};

    unique case (state_q)
      sdfrm_pkg::ST_IDLE: begin
        if (accept) state_d = sdfrm_pkg::ST_COS;
      end
      sdfrm_pkg::ST_COS: begin
        rom_addr = cos_ang[15 -: sdfrm_pkg::TRIG_BITS];
        state_d  = sdfrm_pkg::ST_SIN;
      end
      sdfrm_pkg::ST_SIN: begin
        dx_d    = rom_data;
        state_d = sdfrm_pkg::ST_ORG;
      end
      sdfrm_pkg::ST_ORG: begin
        dy_d    = rom_data;
        ox_d    = sdfrm_pkg::sat_u(29'(col_q) * 29'(scale_q));
        oy_d    = sdfrm_pkg::sat_u(29'(row_q) * 29'(scale_q));
        t_d     = '0;
        step_d  = '0;
        hit_d   = 1'b0;
        state_d = sdfrm_pkg::ST_CHECK;
      end
      sdfrm_pkg::ST_CHECK: begin
        if (step_q == sdfrm_pkg::STEP_W'(sdfrm_pkg::MARCH_STEPS) ||
            t_q >= {3'b000, limit_q}) begin
          state_d = sdfrm_pkg::ST_DONE;
        end else begin
          state_d = sdfrm_pkg::ST_MUL;
        end
      end
      sdfrm_pkg::ST_MUL: begin
        // t is below the limit here, so 19 bits carry it
        px_prod_d = dx_q * $signed({1'b0, t_q[18:0]});
        py_prod_d = dy_q * $signed({1'b0, t_q[18:0]});
        state_d   = sdfrm_pkg::ST_POS;
      end
      sdfrm_pkg::ST_POS: begin
        ux_d    = {px[QW-1], px} - {cx_q[QW-1], cx_q};
        uy_d    = {py[QW-1], py} - {cy_q[QW-1], cy_q};
        state_d = sdfrm_pkg::ST_SQ;
      end
      sdfrm_pkg::ST_SQ: begin
        sqx_d   = ux_sq[40:0];
        sqy_d   = uy_sq[40:0];
        state_d = sdfrm_pkg::ST_SUM;
      end
      sdfrm_pkg::ST_SUM: begin
        chain_head.valid = 1'b1;
        chain_head.rad   = {1'b0, sqx_q} + {1'b0, sqy_q};
        state_d          = sdfrm_pkg::ST_WAIT;
      end
      sdfrm_pkg::ST_WAIT: begin
        if (chain_tail.valid) begin
          if (sd < $signed({6'b000000, thr_q})) begin
            hit_d   = 1'b1;
            state_d = sdfrm_pkg::ST_DONE;
          end else begin
            t_d     = t_q + sd;
            step_d  = step_q + 1'b1;
            state_d = sdfrm_pkg::ST_CHECK;
          end
        end
      end
      sdfrm_pkg::ST_DONE: begin
        if (!last_q) begin
          cnt_d   = cnt_next;
          state_d = sdfrm_pkg::ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          cnt_d       = '0;
          out_valid_d = 1'b1;
          total_d     = cnt_next;
          bright_d    = (bright_scaled > 20'd255) ? 8'd255 : bright_scaled[7:0];
          state_d     = sdfrm_pkg::ST_IDLE;
        end
      end
      default: state_d = sdfrm_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign brightness_o = bright_q;
  assign hit_total_o  = total_q;

  `SDFRM_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != sdfrm_pkg::ST_IDLE, "ray accepted but sequencer idle")
  `SDFRM_ASSERT_NOW(a_root_only_when_waiting, chain_tail.valid, state_q == sdfrm_pkg::ST_WAIT, "root result outside wait state")
  `SDFRM_ASSERT_NOW(a_count_cleared_on_emit, $rose(out_valid_q), cnt_q == '0, "hit count not cleared with result")
  `SDFRM_ASSERT_NOW(a_stall_while_busy, state_q == sdfrm_pkg::ST_WAIT, in_stall_o, "input open while marching")

endmodule

`default_nettype wire

// ===== verif/tb_sdf_ray_march_light_sampler_core.sv =====
// Testbench for sdf_ray_march_light_sampler_core: random and directed rays, with a
// scoreboard that predicts each pixel's grey level. Depends on sdfrm_pkg and the RTL.
`timescale 1ns / 1ps

class grey_scoreboard;
  typedef struct {
    bit [7:0]  grey;
    bit [10:0] hits;
  } pixel_t;

  shortint  sine_tab [1024];
  longint   cen_x, cen_y, radius, scale, limit, thresh;
  int       hit_cnt;
  pixel_t   grey_q [$];
  int       errors;
  int       pixels_seen;
  int       rays_seen;

  function new();
    for (int k = 0; k < 1024; k++) sine_tab[k] = shortint'(turn_sine(k * 64));
    hit_cnt = 0;
    cen_x = 65536; cen_y = 32768; radius = 6554;
    scale = 256; limit = 131072; thresh = 1;
    errors = 0; pixels_seen = 0; rays_seen = 0;
  endfunction

  function longint quarter_sine(longint unsigned u);
    longint unsigned x, x2, term;
    longint acc;
    x = u * 64'd1686629713 / 16384;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) acc = 16384;
    return acc;
  endfunction

  function longint turn_sine(int a);
    int quad, frac;
    longint s;
    quad = (a >> 14) & 3;
    frac = a & 16'h3fff;
    s = (quad & 1) ? quarter_sine(16384 - frac) : quarter_sine(frac);
    return (quad & 2) ? -s : s;
  endfunction

  function longint clamp_q(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function bit ray_hits(longint ox, longint oy, longint dx, longint dy);
    longint t, px, py, ux, uy, sd;
    t = 0;
    for (int i = 0; i < 10 && t < limit; i++) begin
      px = clamp_q(ox + ((dx * t) >>> 14));
      py = clamp_q(oy + ((dy * t) >>> 14));
      ux = px - cen_x;
      uy = py - cen_y;
      sd = longint'(int_root(longint'(ux * ux + uy * uy))) - radius;
      if (sd < thresh) return 1'b1;
      t += sd;
    end
    return 1'b0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [19:0] v);
    case (idx)
      sdfrm_pkg::CFG_CENTER_X:  cen_x = longint'($signed(v));
      sdfrm_pkg::CFG_CENTER_Y:  cen_y = longint'($signed(v));
      sdfrm_pkg::CFG_RADIUS:    radius = longint'(v[18:0]);
      sdfrm_pkg::CFG_SCALE:     scale = longint'(v[16:0]);
      sdfrm_pkg::CFG_LIMIT:     limit = longint'(v[18:0]);
      sdfrm_pkg::CFG_THRESHOLD: thresh = longint'(v[15:0]);
      default: ;
    endcase
  endfunction

  function void note_ray(bit [11:0] col, bit [11:0] row, bit [15:0] ang, bit last);
    longint ox, oy, dx, dy;
    bit [15:0] cang;
    pixel_t p;
    int g;
    rays_seen++;
    ox = clamp_q(longint'(col) * scale);
    oy = clamp_q(longint'(row) * scale);
    cang = ang + 16'd16384;
    dx = sine_tab[cang >> 6];
    dy = sine_tab[ang >> 6];
    if (ray_hits(ox, oy, dx, dy) && hit_cnt < 2047) hit_cnt++;
    if (!last) return;
    g = hit_cnt * 510 / 256;
    if (g > 255) g = 255;
    p.grey = g[7:0];
    p.hits = hit_cnt[10:0];
    grey_q.push_back(p);
    hit_cnt = 0;
  endfunction

  function void check_pixel(bit [7:0] grey, bit [10:0] hits);
    pixel_t p;
    pixels_seen++;
    if (grey_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected pixel: grey %0d hits %0d", grey, hits);
      return;
    end
    p = grey_q.pop_front();
    if (p.grey !== grey || p.hits !== hits) begin
      errors++;
      if (errors <= 10)
        $display("pixel mismatch: grey exp %0d got %0d, hits exp %0d got %0d",
                 p.grey, grey, p.hits, hits);
    end
  endfunction

  function int pending();
    return grey_q.size();
  endfunction
endclass

module tb_sdf_ray_march_light_sampler_core;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 300;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [19:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [11:0] pixel_col_i, pixel_row_i;
  logic [15:0] ray_angle_i;
  logic        last_sample_i;
  logic        out_valid_o, out_stall_i;
  logic [7:0]  brightness_o;
  logic [10:0] hit_total_o;

  grey_scoreboard sb;
  int  mode;          // 0: sender 29 / receiver 83, 1: swapped, 2: no idling
  bit  hold_req;
  int  idle_cnt;

  sdf_ray_march_light_sampler_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: check accepted pixels, then choose next stall
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_pixel(brightness_o, hit_total_o);
      if (hold_req && hold_left == 0) begin
        hold_left = 1500;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (mode == 0) out_stall_i <= ($urandom_range(0, 99) < 83);
      else if (mode == 1) out_stall_i <= ($urandom_range(0, 99) < 29);
      else out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("tb_sdf_ray_march_light_sampler_core: errors");
      $finish;
    end
  end

  task automatic send_ray(bit [11:0] col, bit [11:0] row, bit [15:0] ang, bit last);
    int gap;
    gap = 0;
    if (mode == 0 && $urandom_range(0, 99) < 29) gap = $urandom_range(1, 4);
    if (mode == 1 && $urandom_range(0, 99) < 83) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_col_i   <= col;
    pixel_row_i   <= row;
    ray_angle_i   <= ang;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_ray(col, row, ang, last);
  endtask

  function automatic bit [11:0] pick_coord();
    if ($urandom_range(0, 9) < 3) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, 600));
  endfunction

  // mostly whole pixels (a run of rays closed by the last flag), some loose rays
  task automatic feed_rays(int n);
    int sent, k;
    bit [11:0] c, r;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(1, 12);
        c = pick_coord();
        r = pick_coord();
        for (int i = 0; i < k; i++)
          send_ray(c, r, 16'($urandom_range(0, 65535)), i == k - 1);
        sent += k;
      end else begin
        send_ray(pick_coord(), pick_coord(), 16'($urandom), $urandom_range(0, 1));
        sent++;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic program_all(logic [19:0] cx, logic [19:0] cy, logic [19:0] rad,
                             logic [19:0] scl, logic [19:0] lim, logic [19:0] thr);
    write_reg(sdfrm_pkg::CFG_CENTER_X, cx);
    write_reg(sdfrm_pkg::CFG_CENTER_Y, cy);
    write_reg(sdfrm_pkg::CFG_RADIUS, rad);
    write_reg(sdfrm_pkg::CFG_SCALE, scl);
    write_reg(sdfrm_pkg::CFG_LIMIT, lim);
    write_reg(sdfrm_pkg::CFG_THRESHOLD, thr);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_random();
    program_all(20'($urandom_range(0, 200000)), 20'($urandom_range(0, 200000)),
                20'($urandom_range(0, 40000)), 20'($urandom_range(64, 1024)),
                20'($urandom_range(20000, 524287)), 20'($urandom_range(0, 3000)));
  endtask

  initial begin
    sb = new();
    mode = 2;
    hold_req = 1'b0;
    idle_cnt = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sdfrm_pkg::CFG_CENTER_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    ray_angle_i = '0;
    last_sample_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and the four axis angles under reset settings
    send_ray(12'd0, 12'd0, 16'd0, 1'b1);
    send_ray(12'd4095, 12'd4095, 16'd65535, 1'b1);
    send_ray(12'd256, 12'd128, 16'd16384, 1'b0);
    send_ray(12'd256, 12'd128, 16'd32768, 1'b0);
    send_ray(12'd200, 12'd128, 16'd0, 1'b0);
    send_ray(12'd300, 12'd128, 16'd32768, 1'b1);
    send_ray(12'd256, 12'd0, 16'd16384, 1'b1);
    send_ray(12'd256, 12'd4095, 16'd49152, 1'b1);
    send_ray(12'd4095, 12'd0, 16'd43690, 1'b1);
    wait_drained();
    // zero limit and zero threshold
    program_all(20'd65536, 20'd32768, 20'd6554, 20'd256, 20'd0, 20'd0);
    send_ray(12'd256, 12'd128, 16'd0, 1'b1);
    send_ray(12'd200, 12'd128, 16'd0, 1'b1);
    wait_drained();
    // zero scale: every origin at 0, inside a circle round the origin
    program_all(20'd0, 20'd0, 20'd100000, 20'd0, 20'd131072, 20'd0);
    send_ray(12'd4095, 12'd4095, 16'd12345, 1'b0);
    send_ray(12'd17, 12'd99, 16'd54321, 1'b1);
    wait_drained();

    for (int s = 0; s < 9; s++) begin
      mode = s / 3;
      if (s == 2) program_all(20'h80000, 20'h7ffff, 20'h7ffff, 20'd65536, 20'h7ffff,
                              20'hffff);
      else if (s == 5) program_all(20'h7ffff, 20'h80000, 20'd0, 20'd1, 20'd0, 20'd0);
      else if (s == 7) begin
        program_random();
        program_all(20'(sb.cen_x), 20'(sb.cen_y), 20'($urandom_range(0, 524287)),
                    20'd0, 20'($urandom_range(0, 524287)), 20'($urandom_range(0, 65535)));
      end else program_random();
      if (s == 1) hold_req = 1'b1;
      feed_rays(65);
      if (s == 4) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      feed_rays(65);
      wait_drained();
    end

    $display("rays accepted %0d, pixels checked %0d, across field extremes, zero scale,",
             sb.rays_seen, sb.pixels_seen);
    $display("zero limit and threshold, a long output hold and three idling patterns");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sdf_ray_march_light_sampler_core: clean");
    end else begin
      $display("mismatches: %0d", sb.errors);
      $display("tb_sdf_ray_march_light_sampler_core: errors");
    end
    $finish;
  end
endmodule

// ===== sdf_ray_march_light_sampler_core.f =====
+incdir+src
src/sdfrm_pkg.sv
src/sdfrm_trig_rom.sv
src/sdfrm_sqrt_cell.sv
src/sdfrm_sqrt_chain.sv
src/sdf_ray_march_light_sampler_core.sv
verif/tb_sdf_ray_march_light_sampler_core.sv
